// ----- rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/itp_pkg.sv -----
`default_nettype none

package itp_pkg;

  localparam int ACC_W  = 64;
  localparam int BYTE_W = 8;
  localparam int ST_W   = 2;

  typedef enum logic [3:0] {
    PH_START     = 4'd0,
    PH_ULEAD     = 4'd1,
    PH_ZERO      = 4'd2,
    PH_ZERO_TAIL = 4'd3,
    PH_HEX_PRE   = 4'd4,
    PH_DEC_PRE   = 4'd5,
    PH_DEC       = 4'd6,
    PH_HEX       = 4'd7,
    PH_ERR       = 4'd8
  } phase_t;

  localparam logic [ST_W-1:0] ST_OK  = 2'd0;
  localparam logic [ST_W-1:0] ST_BAD = 2'd1;
  localparam logic [ST_W-1:0] ST_OOB = 2'd2;

  localparam logic [ACC_W-1:0] MAX_DIV10      = 64'd1844674407370955161;
  localparam logic [3:0]       MAX_LAST_DIGIT = 4'd5;
  localparam logic [ACC_W-1:0] SIGNED_MAX     = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [ACC_W-1:0] SIGNED_MIN_MAG = 64'h8000_0000_0000_0000;

  // Classified request as it travels from the front end to the back end.
  typedef struct packed {
    logic [3:0] digit;     // digit value, valid when is_hex
    logic       is_dec;
    logic       is_hex;
    logic       is_under;
    logic       is_plus;
    logic       is_minus;
    logic       is_x;
    logic       is_d;
    logic       has_byte;
    logic       last;
    logic       sgn;       // signed_mode sampled with the request
  } tok_t;

  // End-of-text record before the sign/range step.
  typedef struct packed {
    logic [ACC_W-1:0] val;
    logic [ST_W-1:0]  st;
    logic             neg;
    logic             sgn;
  } fin_t;

endpackage

`default_nettype wire

// ----- rtl/itp_in_if.sv -----
`default_nettype none

interface itp_in_if import itp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] byte_value;
  logic              has_byte;
  logic              last;

  modport source (output valid, byte_value, has_byte, last, input ready);
  modport sink   (input valid, byte_value, has_byte, last, output ready);
endinterface

`default_nettype wire

// ----- rtl/itp_out_if.sv -----
`default_nettype none

interface itp_out_if import itp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ACC_W-1:0] value;
  logic [ST_W-1:0]  status;

  modport source (output valid, value, status, input ready);
  modport sink   (input valid, value, status, output ready);
endinterface

`default_nettype wire

// ----- rtl/integer_text_parser.sv -----
// Channel   Dir   Payload                        Accepted when
// text      in    byte_value[8] has_byte last    text.valid && text.ready
// result    out   value[64] status[2]            result.valid && result.ready
// cfg       in    cfg_data (signed_mode)         cfg_we
//
// One request per cycle unless stalled; the front classifies and queues, the
// back runs one queued request per cycle (one x10 shift-add or hex shift).
// A taken last request fills the finish register, then the result register.
// Synchronous active-high reset; no clearing pass after reset.
// A waiting result stalls the back only on a later last request; the queue of
// QUEUE_DEPTH entries absorbs bytes meanwhile before text.ready drops.
`default_nettype none

module integer_text_parser import itp_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic cfg_data,
  itp_in_if.sink    text,
  itp_out_if.source result
);

  logic push_valid;
  logic push_ready;
  tok_t push_data;
  logic pop_valid;
  logic pop_ready;
  tok_t pop_data;

  itp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .text       (text),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready)
  );

  itp_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data),
    .pop_ready  (pop_ready)
  );

  itp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .tok_valid (pop_valid),
    .tok       (pop_data),
    .tok_ready (pop_ready),
    .result    (result)
  );

endmodule

`default_nettype wire

// ----- rtl/itp_fifo.sv -----
`default_nettype none
`include "assert_macros.svh"

module itp_fifo import itp_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push_valid,
  input  tok_t      push_data,
  output logic      push_ready,
  output logic      pop_valid,
  output tok_t      pop_data,
  input  wire logic pop_ready
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  tok_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] cnt;
  logic             push;
  logic             pop;

  assign push_ready = (cnt != CNT_W'(DEPTH));
  assign pop_valid  = (cnt != '0);
  assign pop_data   = mem[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        cnt <= cnt + 1'b1;
      end else if (pop && !push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  `ASSERT_NOW(a_cnt_range, clk, rst, 1'b1, cnt <= CNT_W'(DEPTH), "queue count past depth")
  `ASSERT_NEXT(a_cnt_up, clk, rst, push && !pop, cnt == CNT_W'($past(cnt) + 1'b1), "count lost a push")
  `ASSERT_NEXT(a_cnt_down, clk, rst, pop && !push, cnt == CNT_W'($past(cnt) - 1'b1), "count lost a pop")

endmodule

`default_nettype wire

// ----- rtl/itp_front.sv -----
`default_nettype none

module itp_front import itp_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic cfg_data,
  itp_in_if.sink    text,
  output logic      push_valid,
  output tok_t      push_data,
  input  wire logic push_ready
);

  logic              signed_mode;
  logic [BYTE_W-1:0] b;
  logic              is_dec;
  logic              is_alpha_hex;

  always_ff @(posedge clk) begin
    if (rst) begin
      signed_mode <= 1'b0;
    end else if (cfg_we) begin
      signed_mode <= cfg_data;
    end
  end

  assign b = text.byte_value;
  assign is_dec = (b >= 8'h30) && (b <= 8'h39);
  // 'A'..'F' and 'a'..'f' share low nibbles 1..6
  assign is_alpha_hex = ((b >= 8'h41) && (b <= 8'h46)) || ((b >= 8'h61) && (b <= 8'h66));

  always_comb begin
    push_data.digit    = is_dec ? b[3:0] : b[3:0] + 4'd9;
    push_data.is_dec   = is_dec;
    push_data.is_hex   = is_dec || is_alpha_hex;
    push_data.is_under = (b == 8'h5F);
    push_data.is_plus  = (b == 8'h2B);
    push_data.is_minus = (b == 8'h2D);
    push_data.is_x     = (b == 8'h78) || (b == 8'h58);
    push_data.is_d     = (b == 8'h64) || (b == 8'h44);
    push_data.has_byte = text.has_byte;
    push_data.last     = text.last;
    push_data.sgn      = signed_mode;
  end

  assign push_valid = text.valid;
  assign text.ready = push_ready;

endmodule

`default_nettype wire

// ----- rtl/itp_back.sv -----
`default_nettype none
`include "assert_macros.svh"

module itp_back import itp_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic tok_valid,
  input  tok_t      tok,
  output logic      tok_ready,
  itp_out_if.source result
);

  phase_t           phase, phase_next;
  logic [ACC_W-1:0] acc, acc_next;
  logic             neg, neg_next;
  logic [ST_W-1:0]  err, err_next;

  logic             fin_valid;
  fin_t             fin, fin_d;
  logic             out_free;
  logic             fin_free;
  logic             pop;
  logic             fail_bad;
  logic             fail_oob;
  logic [ACC_W-1:0] acc_x10;
  logic             dec_ovf;
  logic [ACC_W-1:0] res_val;
  logic [ST_W-1:0]  res_st;

  assign out_free  = !result.valid || result.ready;
  assign fin_free  = !fin_valid || out_free;
  assign tok_ready = !tok.last || fin_free;
  assign pop       = tok_valid && tok_ready;

  assign acc_x10 = (acc << 3) + (acc << 1) + ACC_W'(tok.digit);
  assign dec_ovf = (acc > MAX_DIV10) || ((acc == MAX_DIV10) && (tok.digit > MAX_LAST_DIGIT));

  always_comb begin
    phase_next = phase;
    acc_next   = acc;
    neg_next   = neg;
    err_next   = err;
    fail_bad   = 1'b0;
    fail_oob   = 1'b0;
    if (pop && tok.has_byte) begin
      unique case (phase)
        PH_START: begin
          if (tok.is_under) begin
            phase_next = PH_START;
          end else if (tok.sgn && tok.is_minus) begin
            neg_next   = 1'b1;
            phase_next = PH_ULEAD;
          end else if (tok.sgn && tok.is_plus) begin
            phase_next = PH_ULEAD;
          end else if (tok.is_dec && tok.digit == 4'd0) begin
            phase_next = PH_ZERO;
          end else if (tok.is_dec) begin
            acc_next   = ACC_W'(tok.digit);
            phase_next = PH_DEC;
          end else begin
            fail_bad = 1'b1;
          end
        end
        PH_ULEAD: begin
          if (tok.is_under) begin
            phase_next = PH_ULEAD;
          end else if (tok.is_dec && tok.digit == 4'd0) begin
            phase_next = PH_ZERO;
          end else if (tok.is_dec) begin
            acc_next   = ACC_W'(tok.digit);
            phase_next = PH_DEC;
          end else begin
            fail_bad = 1'b1;
          end
        end
        PH_ZERO: begin
          if (tok.is_under) begin
            phase_next = PH_ZERO_TAIL;
          end else if (tok.is_x) begin
            phase_next = PH_HEX_PRE;
          end else if (tok.is_d) begin
            phase_next = PH_DEC_PRE;
          end else begin
            fail_bad = 1'b1;
          end
        end
        PH_ZERO_TAIL: begin
          fail_bad = !tok.is_under;
        end
        PH_HEX_PRE: begin
          if (tok.is_under) begin
            phase_next = PH_HEX_PRE;
          end else if (tok.is_hex) begin
            acc_next   = ACC_W'(tok.digit);
            phase_next = PH_HEX;
          end else begin
            fail_bad = 1'b1;
          end
        end
        PH_DEC_PRE: begin
          if (tok.is_under) begin
            phase_next = PH_DEC_PRE;
          end else if (tok.is_dec) begin
            acc_next   = ACC_W'(tok.digit);
            phase_next = PH_DEC;
          end else begin
            fail_bad = 1'b1;
          end
        end
        PH_DEC: begin
          if (tok.is_under) begin
            phase_next = PH_DEC;
          end else if (!tok.is_dec) begin
            fail_bad = 1'b1;
          end else if (dec_ovf) begin
            fail_oob = 1'b1;
          end else begin
            acc_next = acc_x10;
          end
        end
        PH_HEX: begin
          if (tok.is_under) begin
            phase_next = PH_HEX;
          end else if (!tok.is_hex) begin
            fail_bad = 1'b1;
          end else if (acc[ACC_W-1:ACC_W-4] != 4'd0) begin
            fail_oob = 1'b1;
          end else begin
            acc_next = {acc[ACC_W-5:0], tok.digit};
          end
        end
        default: begin
          phase_next = phase;
        end
      endcase
      if (fail_bad || fail_oob) begin
        phase_next = PH_ERR;
        acc_next   = '0;
        err_next   = fail_oob ? ST_OOB : ST_BAD;
      end
    end
  end

  // End-of-text record, taken from the state after this request's byte.
  always_comb begin
    fin_d.neg = neg_next;
    fin_d.sgn = tok.sgn;
    fin_d.val = '0;
    fin_d.st  = ST_OK;
    unique case (phase_next)
      PH_ZERO, PH_ZERO_TAIL: fin_d.st = ST_OK;
      PH_DEC, PH_HEX: fin_d.val = acc_next;
      PH_ERR: fin_d.st = err_next;
      default: fin_d.st = ST_BAD;
    endcase
  end

  // Sign and range step on the finish register.
  always_comb begin
    res_val = fin.val;
    res_st  = fin.st;
    if (res_st == ST_OK && fin.sgn) begin
      if (fin.neg) begin
        if (res_val > SIGNED_MIN_MAG) begin
          res_st = ST_OOB;
        end else begin
          res_val = ~res_val + 64'd1;
        end
      end else if (res_val > SIGNED_MAX) begin
        res_st = ST_OOB;
      end
    end
    if (res_st != ST_OK) begin
      res_val = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_START;
      acc   <= '0;
      neg   <= 1'b0;
      err   <= ST_OK;
    end else if (pop && tok.last) begin
      phase <= PH_START;
      acc   <= '0;
      neg   <= 1'b0;
      err   <= ST_OK;
    end else begin
      phase <= phase_next;
      acc   <= acc_next;
      neg   <= neg_next;
      err   <= err_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid    <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      if (pop && tok.last) begin
        fin_valid <= 1'b1;
      end else if (out_free) begin
        fin_valid <= 1'b0;
      end
      if (out_free) begin
        result.valid <= fin_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && tok.last) begin
      fin <= fin_d;
    end
    if (out_free && fin_valid) begin
      result.value  <= res_val;
      result.status <= res_st;
    end
  end

  `ASSERT_NOW(a_err_acc_zero, clk, rst, phase == PH_ERR, acc == '0, "accumulator not cleared on error")
  `ASSERT_NEXT(a_fin_held, clk, rst, fin_valid && !out_free, fin_valid, "finish record dropped")
  `ASSERT_NOW(a_err_value_zero, clk, rst, result.valid && result.status != ST_OK, result.value == '0, "nonzero value with error status")

endmodule

`default_nettype wire
